FILE: design/pdarr_pkg.sv
// Shared types, codes and defaults for the positional insert/delete array.
package pdarr_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;

    typedef enum logic [3:0] {
        ACT_INS_AT    = 4'd0,
        ACT_INS_AFTER = 4'd1,
        ACT_INS_START = 4'd2,
        ACT_INS_END   = 4'd3,
        ACT_DEL_AT    = 4'd4,
        ACT_DEL_BEF   = 4'd5,
        ACT_DEL_AFTER = 4'd6,
        ACT_DEL_FIRST = 4'd7,
        ACT_DEL_END   = 4'd8,
        ACT_READ      = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_READ = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [DATA_W-1:0]   data;
    } cell_ctrl_t;

endpackage

FILE: design/pdarr_cell.sv
// One entry cell of the array: holds a value, shifts to or from its neighbors.
module pdarr_cell
    import pdarr_pkg::*;
#(
    parameter int IW  = 6,
    parameter int IDX = 0
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic [IW-1:0]             idx,
    input  logic signed [DATA_W-1:0]  left,
    input  logic signed [DATA_W-1:0]  right,
    output logic signed [DATA_W-1:0]  q,
    output logic signed [DATA_W-1:0]  tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_INS:
            begin
                if (MY_IDX > idx)
                begin
                    entry_next = left;
                end
                else if (MY_IDX == idx)
                begin
                    entry_next = ctrl.data;
                end
            end
            OP_DEL:
            begin
                if (MY_IDX >= idx)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q   = entry_reg;
    assign tap = (MY_IDX == idx) ? entry_reg : '0;

endmodule

FILE: design/pdarr_dec.sv
// Request decoder: checks count and position and picks the target index.
module pdarr_dec
    import pdarr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = 7,
    parameter int IW    = 6
)
(
    input  logic [3:0]     action,
    input  logic [CW-1:0]  position,
    input  logic [CW-1:0]  count,
    output status_t        status,
    output cell_op_t       op,
    output logic [IW-1:0]  idx,
    output logic [CW-1:0]  new_count
);

    logic          is_full;
    logic          is_empty;
    logic          is_ins;
    logic          is_rem;
    logic          is_rd;
    logic          ok;
    logic [CW:0]   pos_w;
    logic [CW:0]   cnt_w;
    logic [CW:0]   tgt;

    assign is_full  = (count == CW'(DEPTH));
    assign is_empty = (count == '0);
    assign pos_w    = {1'b0, position};
    assign cnt_w    = {1'b0, count};

    always_comb
    begin
        is_ins    = 1'b0;
        is_rem    = 1'b0;
        is_rd     = 1'b0;
        ok        = 1'b1;
        tgt       = '0;
        status    = ST_OK;
        op        = OP_HOLD;
        new_count = count;
        case (action)
            ACT_INS_AT:
            begin
                is_ins = 1'b1;
                ok     = pos_w <= cnt_w;
                tgt    = pos_w;
            end
            ACT_INS_AFTER:
            begin
                is_ins = 1'b1;
                ok     = pos_w < cnt_w;
                tgt    = pos_w + 1'b1;
            end
            ACT_INS_START:
            begin
                is_ins = 1'b1;
            end
            ACT_INS_END:
            begin
                is_ins = 1'b1;
                tgt    = cnt_w;
            end
            ACT_DEL_AT:
            begin
                is_rem = 1'b1;
                ok     = pos_w < cnt_w;
                tgt    = pos_w;
            end
            ACT_READ:
            begin
                is_rd = 1'b1;
                ok    = pos_w < cnt_w;
                tgt   = pos_w;
            end
            ACT_DEL_BEF:
            begin
                is_rem = 1'b1;
                ok     = (pos_w != '0) && (pos_w <= cnt_w);
                tgt    = pos_w - 1'b1;
            end
            ACT_DEL_AFTER:
            begin
                is_rem = 1'b1;
                tgt    = pos_w + 1'b1;
                ok     = tgt < cnt_w;
            end
            ACT_DEL_FIRST:
            begin
                is_rem = 1'b1;
            end
            ACT_DEL_END:
            begin
                is_rem = 1'b1;
                tgt    = cnt_w - 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        if (is_ins)
        begin
            if (is_full)
            begin
                status = ST_FULL;
            end
            else if (!ok)
            begin
                status = ST_BADPOS;
            end
            else
            begin
                op        = OP_INS;
                new_count = count + 1'b1;
            end
        end
        else if (is_rem || is_rd)
        begin
            if (is_empty)
            begin
                status = ST_EMPTY;
            end
            else if (!ok)
            begin
                status = ST_BADPOS;
            end
            else if (is_rd)
            begin
                op = OP_READ;
            end
            else
            begin
                op        = OP_DEL;
                new_count = count - 1'b1;
            end
        end
        else
        begin
            status = ST_BADPOS;
        end
    end

    assign idx = tgt[IW-1:0];

endmodule

FILE: design/positional_insert_delete_array.sv
// Top level of the positional insert/delete array: decode stage and row of entry cells.
// The block keeps up to DEPTH signed 32-bit entries in a row of cells, one entry per
// cell. A transaction is decoded against the live count in the cycle in which it is
// accepted and is held in the execute stage. All cells then carry it out at once when
// that stage fires, every later entry moving one cell up for an insert or one cell down
// for a delete, and the result is registered into the output stage. One transaction is
// accepted every cycle as long as results are taken. A result that is not taken holds
// the execute stage, and the input stalls once that stage is occupied. Exactly one
// result comes back for every transaction.
module positional_insert_delete_array
    import pdarr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0]                          action,
    input  logic [$clog2(DEPTH+1)-1:0]          position,
    input  logic signed [DATA_W-1:0]            value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [$clog2(DEPTH+1)-1:0]          new_count,
    output logic signed [DATA_W-1:0]            read_value
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic                     in_fire;
    logic                     exec_fire;

    status_t                  dec_status;
    cell_op_t                 dec_op;
    logic [IW-1:0]            dec_idx;
    logic [CW-1:0]            dec_count;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;

    logic                     cmd_valid_reg;
    logic                     cmd_valid_next;
    cell_op_t                 op_reg;
    logic [IW-1:0]            idx_reg;
    logic signed [DATA_W-1:0] val_reg;
    status_t                  st_reg;
    logic [CW-1:0]            cnt_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    logic [CW-1:0]            out_count_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] out_value_next;

    cell_ctrl_t               cell_ctrl;
    logic signed [DATA_W-1:0] cell_q   [DEPTH];
    logic signed [DATA_W-1:0] cell_tap [DEPTH];
    logic signed [DATA_W-1:0] tap_or;

    assign exec_fire = cmd_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !cmd_valid_reg || exec_fire;
    assign in_fire   = in_valid && in_ready;

    pdarr_dec #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .IW    (IW)
    ) u_dec (
        .action    (action),
        .position  (position),
        .count     (count_reg),
        .status    (dec_status),
        .op        (dec_op),
        .idx       (dec_idx),
        .new_count (dec_count)
    );

    always_comb
    begin
        count_next     = in_fire ? dec_count : count_reg;
        cmd_valid_next = in_fire ? 1'b1 : (exec_fire ? 1'b0 : cmd_valid_reg);
        out_valid_next = exec_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= dec_op;
            idx_reg <= dec_idx;
            val_reg <= value;
            st_reg  <= dec_status;
            cnt_reg <= dec_count;
        end
        if (exec_fire)
        begin
            out_status_reg <= st_reg;
            out_count_reg  <= cnt_reg;
            out_value_reg  <= out_value_next;
        end
    end

    assign cell_ctrl.op   = exec_fire ? op_reg : OP_HOLD;
    assign cell_ctrl.data = val_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[i+1];
        end

        pdarr_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .ctrl  (cell_ctrl),
            .idx   (idx_reg),
            .left  (left_d),
            .right (right_d),
            .q     (cell_q[i]),
            .tap   (cell_tap[i])
        );
    end

    always_comb
    begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            tap_or = tap_or | cell_tap[k];
        end
        out_value_next = ((op_reg == OP_DEL) || (op_reg == OP_READ)) ? tap_or : '0;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign new_count  = out_count_reg;
    assign read_value = out_value_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("live count exceeds capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_FULL)) |-> (out_count_reg == CW'(DEPTH)))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_EMPTY)) |-> (out_count_reg == '0))
        else $error("empty status with nonzero count");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (dec_op == OP_INS)) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not raise the count by one");

endmodule

FILE: verif/tb_positional_insert_delete_array.sv
// Self-checking testbench for the positional insert/delete array, predicted by a shadow array.
module tb_positional_insert_delete_array
    import pdarr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = $clog2(DEPTH_DEF + 1);

    typedef struct {
        status_t                    st;
        logic [CW-1:0]              cnt;
        logic signed [DATA_W-1:0]   rv;
    } response_t;

    class array_shadow;
        logic signed [DATA_W-1:0] cells [DEPTH_DEF];
        int        live;
        int        peak;
        int        errors;
        int        status_seen [4];
        response_t pending_responses [$];

        function void note_request(logic [3:0] act, logic [CW-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            response_t r;
            int        idx;
            int        p;
            int        i;
            bit        ok;
            r.st = ST_OK;
            r.rv = '0;
            idx = 0;
            ok = 1'b1;
            p = int'(pos);
            if (act <= ACT_INS_END) begin
                if (live >= DEPTH_DEF) begin
                    r.st = ST_FULL;
                end
                else begin
                    case (act)
                        ACT_INS_AT:
                        begin
                            idx = p;
                            ok = (p <= live);
                        end
                        ACT_INS_AFTER:
                        begin
                            idx = p + 1;
                            ok = (p < live);
                        end
                        ACT_INS_START: idx = 0;
                        default:       idx = live;
                    endcase
                    if (!ok)
                        r.st = ST_BADPOS;
                end
                if (r.st == ST_OK) begin
                    for (i = live; i > idx; i--)
                        cells[i] = cells[i-1];
                    cells[idx] = val;
                    live++;
                end
            end
            else if (act <= ACT_READ) begin
                if (live == 0) begin
                    r.st = ST_EMPTY;
                end
                else begin
                    case (act)
                        ACT_DEL_AT, ACT_READ:
                        begin
                            idx = p;
                            ok = (p < live);
                        end
                        ACT_DEL_BEF:
                        begin
                            ok = (p >= 1) && (p <= live);
                            idx = ok ? p - 1 : 0;
                        end
                        ACT_DEL_AFTER:
                        begin
                            idx = p + 1;
                            ok = (idx < live);
                        end
                        ACT_DEL_FIRST: idx = 0;
                        default:       idx = live - 1;
                    endcase
                    if (!ok)
                        r.st = ST_BADPOS;
                end
                if (r.st == ST_OK) begin
                    r.rv = cells[idx];
                    if (act != ACT_READ) begin
                        for (i = idx; i + 1 < live; i++)
                            cells[i] = cells[i+1];
                        live--;
                    end
                end
            end
            else begin
                r.st = ST_BADPOS;
            end
            r.cnt = live[CW-1:0];
            if (live > peak)
                peak = live;
            status_seen[r.st]++;
            pending_responses.push_back(r);
        endfunction

        function void check_response(logic [1:0] st, logic [CW-1:0] cnt,
                                     logic signed [DATA_W-1:0] rv);
            response_t want;
            if (pending_responses.size() == 0) begin
                $error("result with no transaction outstanding: status %0d count %0d value %0d",
                       st, cnt, rv);
                errors++;
                return;
            end
            want = pending_responses.pop_front();
            if (st !== want.st) begin
                $error("status: expected %0d, got %0d", want.st, st);
                errors++;
            end
            if (cnt !== want.cnt) begin
                $error("new_count: expected %0d, got %0d", want.cnt, cnt);
                errors++;
            end
            if (rv !== want.rv) begin
                $error("read_value: expected %0d, got %0d", want.rv, rv);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [3:0]                 action;
    logic [CW-1:0]              position;
    logic signed [DATA_W-1:0]   value;
    logic                       out_valid;
    logic                       out_ready;
    logic [1:0]                 status;
    logic [CW-1:0]              new_count;
    logic signed [DATA_W-1:0]   read_value;

    int          send_idle;
    int          recv_idle;
    array_shadow model;

    positional_insert_delete_array #(.DEPTH(DEPTH_DEF)) uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .new_count  (new_count),
        .read_value (read_value)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send_req(input logic [3:0] act, input logic [CW-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
        if ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model.note_request(act, pos, val);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 10) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_random(input bit growing);
        logic [3:0]    act;
        logic [CW-1:0] pos;
        int            r;
        int            lv;
        lv = model.live;
        r = $urandom_range(0, 99);
        if (r < 3)
            act = 4'($urandom_range(10, 15));
        else if (r < 18)
            act = ACT_READ;
        else if ($urandom_range(0, 99) < (growing ? 75 : 25))
            act = 4'($urandom_range(ACT_INS_AT, ACT_INS_END));
        else
            act = 4'($urandom_range(ACT_DEL_AT, ACT_DEL_END));
        r = $urandom_range(0, 99);
        if (r < 8) begin
            pos = CW'($urandom_range(0, (1 << CW) - 1));
        end
        else if (r < 20) begin
            case ($urandom_range(0, 3))
                0:       pos = '0;
                1:       pos = CW'((lv > 0) ? lv - 1 : 0);
                2:       pos = CW'(lv);
                default: pos = CW'(lv + 1);
            endcase
        end
        else begin
            pos = CW'($urandom_range(0, lv));
        end
        send_req(act, pos, pick_value());
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                model.check_response(status, new_count, read_value);
            out_ready <= rst_n ? ($urandom_range(0, 99) >= recv_idle) : 1'b0;
        end
    end

    initial
    begin
        bit growing;
        int n;
        int waited;
        model     = new();
        send_idle = 31;
        recv_idle = 45;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        out_ready <= 1'b0;
        action    <= ACT_READ;
        position  <= '0;
        value     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Requests against an empty array, then a short build-up and tear-down.
        send_req(ACT_READ,      0,   0);
        send_req(ACT_DEL_FIRST, 0,   0);
        send_req(ACT_DEL_END,   127, 0);
        send_req(ACT_INS_AFTER, 0,   5);
        send_req(ACT_INS_AT,    1,   6);
        send_req(ACT_INS_AT,    0,   32'sh8000_0000);
        send_req(ACT_INS_END,   127, 32'sh7fff_ffff);
        send_req(ACT_INS_START, 127, -32'sd1);
        send_req(ACT_INS_AFTER, 0,   0);
        send_req(ACT_INS_AT,    4,   32'sd12345);
        send_req(ACT_READ,      4,   0);
        send_req(ACT_READ,      5,   0);
        send_req(ACT_READ,      127, 0);
        send_req(ACT_DEL_BEF,   0,   0);
        send_req(ACT_DEL_BEF,   5,   0);
        send_req(ACT_DEL_AFTER, 3,   0);
        send_req(ACT_DEL_AFTER, 0,   0);
        send_req(ACT_INS_AT,    64,  1);
        send_req(ACT_INS_AFTER, 127, 1);
        send_req(4'd10,         0,   0);
        send_req(4'd15,         127, -32'sd1);
        send_req(ACT_DEL_AT,    0,   0);
        send_req(ACT_DEL_FIRST, 0,   0);
        send_req(ACT_DEL_END,   0,   0);

        // The fill bias flips at the full and empty ends so both limits are hit repeatedly.
        growing = 1'b1;
        for (n = 0; n < 800; n++) begin
            if (n == 267) begin
                send_idle = 45;
                recv_idle = 31;
            end
            else if (n == 534) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (model.live == DEPTH_DEF && $urandom_range(0, 7) == 0)
                growing = 1'b0;
            else if (model.live == 0 && $urandom_range(0, 7) == 0)
                growing = 1'b1;
            send_random(growing);
        end
        in_valid <= 1'b0;

        waited = 0;
        while (model.pending_responses.size() != 0 && waited < 10000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (model.pending_responses.size() != 0) begin
            $error("%0d expected results never arrived", model.pending_responses.size());
            model.errors++;
        end

        $display("Covered %0d transactions: %0d ok, %0d bad position, %0d full, %0d empty.",
                 model.status_seen[ST_OK] + model.status_seen[ST_BADPOS]
                 + model.status_seen[ST_FULL] + model.status_seen[ST_EMPTY],
                 model.status_seen[ST_OK], model.status_seen[ST_BADPOS],
                 model.status_seen[ST_FULL], model.status_seen[ST_EMPTY]);
        $display("Highest entry count reached was %0d of %0d.", model.peak, DEPTH_DEF);
        if (model.errors == 0)
            $display("positional_insert_delete_array regression: pass");
        else
            $display("positional_insert_delete_array regression: fail");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("positional_insert_delete_array regression: fail");
        $finish;
    end

endmodule
